### src/qft_pkg.sv
package qft_pkg;

  localparam int DELIM_SLOTS = 4;
  localparam int QUOTE_SLOTS = 2;

  localparam int DELIM_BYTES_W = 32;
  localparam int DELIM_COUNT_W = 3;
  localparam int QUOTE_BYTES_W = 16;
  localparam int QUOTE_COUNT_W = 2;
  localparam int KEEP_MODE_W   = 3;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [7:0] BACKSLASH = 8'h5C;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELIM_BYTES = 3'd0,
    REG_DELIM_COUNT = 3'd1,
    REG_QUOTE_BYTES = 3'd2,
    REG_QUOTE_COUNT = 3'd3,
    REG_KEEP_MODE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       byte_kept;
    logic       token_done;
    logic       token_empty;
  } out_item_t;

  // Classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
    logic       is_delim;
    logic       is_quote;     // quote match, quoting enabled
    logic       is_bslash;    // backslash, quoting enabled
    logic       drop_quote;
    logic       drop_bslash;
  } cls_item_t;

endpackage

### src/qft_front.sv
module qft_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [31:0]                 cfg_wdata,
  input  qft_pkg::in_item_t           in_data,
  output qft_pkg::cls_item_t          cls_data
);
  import qft_pkg::*;

  logic [DELIM_BYTES_W-1:0] delim_bytes_r;
  logic [DELIM_COUNT_W-1:0] delim_count_r;
  logic [QUOTE_BYTES_W-1:0] quote_bytes_r;
  logic [QUOTE_COUNT_W-1:0] quote_count_r;
  logic [KEEP_MODE_W-1:0]   keep_mode_r;

  logic is_delim;
  logic is_quote;
  logic quoting;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_bytes_r <= DELIM_BYTES_W'(32);
      delim_count_r <= DELIM_COUNT_W'(1);
      quote_bytes_r <= QUOTE_BYTES_W'(34);
      quote_count_r <= QUOTE_COUNT_W'(1);
      keep_mode_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELIM_BYTES: delim_bytes_r <= cfg_wdata[DELIM_BYTES_W-1:0];
        REG_DELIM_COUNT: delim_count_r <= cfg_wdata[DELIM_COUNT_W-1:0];
        REG_QUOTE_BYTES: quote_bytes_r <= cfg_wdata[QUOTE_BYTES_W-1:0];
        REG_QUOTE_COUNT: quote_count_r <= cfg_wdata[QUOTE_COUNT_W-1:0];
        REG_KEEP_MODE:   keep_mode_r   <= cfg_wdata[KEEP_MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot compares: only slots below the count take part
  always_comb begin
    is_delim = 1'b0;
    for (int i = 0; i < DELIM_SLOTS; i++) begin
      if (DELIM_COUNT_W'(i) < delim_count_r &&
          in_data.text_byte == delim_bytes_r[8*i +: 8])
        is_delim = 1'b1;
    end
  end

  always_comb begin
    is_quote = 1'b0;
    for (int i = 0; i < QUOTE_SLOTS; i++) begin
      if (QUOTE_COUNT_W'(i) < quote_count_r &&
          in_data.text_byte == quote_bytes_r[8*i +: 8])
        is_quote = 1'b1;
    end
  end

  assign quoting = (quote_count_r != '0);

  always_comb begin
    cls_data.text_byte     = in_data.text_byte;
    cls_data.end_of_string = in_data.end_of_string;
    cls_data.is_delim      = is_delim;
    cls_data.is_quote      = is_quote;
    cls_data.is_bslash     = quoting && (in_data.text_byte == BACKSLASH);
    cls_data.drop_quote    = !keep_mode_r[0];
    cls_data.drop_bslash   = !keep_mode_r[0] && !keep_mode_r[2];
  end

endmodule

### src/qft_queue.sv
module qft_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qft_pkg::cls_item_t  push_data,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output qft_pkg::cls_item_t  head_data
);
  import qft_pkg::*;

  cls_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + QPTR_W'(1);
  endfunction

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

### src/qft_back.sv
module qft_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  qft_pkg::cls_item_t  q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output qft_pkg::out_item_t  out_data
);
  import qft_pkg::*;

  typedef enum logic {ST_GAP, ST_TOKEN} state_t;

  state_t    state_r, state_nxt;
  logic      quote_open_r, quote_open_nxt;
  logic      esc_r, esc_nxt;
  logic      kept_any_r, kept_any_nxt;
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  logic esc_cur, quote_cur, kept_cur;
  logic q_hit, b_hit, keep;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt      = state_r;
    quote_open_nxt = quote_open_r;
    esc_nxt        = esc_r;
    kept_any_nxt   = kept_any_r;
    out_nxt        = '0;

    // Fresh token starts with clear flags
    esc_cur   = (state_r == ST_TOKEN) && esc_r;
    quote_cur = (state_r == ST_TOKEN) && quote_open_r;
    kept_cur  = (state_r == ST_TOKEN) && kept_any_r;
    q_hit     = q_data.is_quote && !esc_cur;
    b_hit     = q_data.is_bslash && !esc_cur;
    keep      = !(q_hit && q_data.drop_quote) && !(b_hit && q_data.drop_bslash);

    if (state_r == ST_GAP && q_data.is_delim) begin
      // Skip delimiter; end of string here marks end of tokens
      out_nxt.token_done  = q_data.end_of_string;
      out_nxt.token_empty = q_data.end_of_string;
    end else if (state_r == ST_TOKEN && q_data.is_delim && !quote_open_r && !esc_r) begin
      out_nxt.token_done  = 1'b1;
      out_nxt.token_empty = !kept_any_r;
      state_nxt      = ST_GAP;
      quote_open_nxt = 1'b0;
      esc_nxt        = 1'b0;
      kept_any_nxt   = 1'b0;
    end else begin
      state_nxt      = ST_TOKEN;
      quote_open_nxt = quote_cur ^ q_hit;
      esc_nxt        = b_hit;
      kept_any_nxt   = kept_cur || keep;
      out_nxt.token_byte = keep ? q_data.text_byte : 8'h00;
      out_nxt.byte_kept  = keep;
      if (q_data.end_of_string) begin
        out_nxt.token_done  = 1'b1;
        out_nxt.token_empty = !(kept_cur || keep);
        state_nxt      = ST_GAP;
        quote_open_nxt = 1'b0;
        esc_nxt        = 1'b0;
        kept_any_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_GAP;
      quote_open_r <= 1'b0;
      esc_r        <= 1'b0;
      kept_any_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      out_r        <= '0;
    end else begin
      if (q_pop) begin
        state_r      <= state_nxt;
        quote_open_r <= quote_open_nxt;
        esc_r        <= esc_nxt;
        kept_any_r   <= kept_any_nxt;
        out_valid_r  <= 1'b1;
        out_r        <= out_nxt;
      end else if (!out_stall) begin
        // Drop the result once the transaction completes
        out_valid_r  <= 1'b0;
      end
    end
  end

endmodule

### src/quoted_field_tokenizer.sv
// Quoted field tokenizer: one result per input byte, in order.
// A byte accepted is classified into a two-entry queue and its result is registered
// in the output register when the back pops it from the queue.
// Throughput: one byte per cycle; the queue fills and in_stall rises only while
// out_stall holds the output register.
// Reset (rst_n low, synchronous): queue and output emptied, token state cleared,
// configuration back to delimiter space, quote double-quote, keep_mode 0.
module quoted_field_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qft_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qft_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import qft_pkg::*;

  cls_item_t cls_data;
  cls_item_t head_data;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      push;

  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  qft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cls_data  (cls_data)
  );

  qft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (head_data)
  );

  qft_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (head_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import qft_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REG_COUNT   = 5;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 115;
  localparam logic [7:0] ESC_BYTE = 8'h5C;

  typedef struct packed {
    logic [31:0] dbytes;
    logic [2:0]  dcount;
    logic [15:0] qbytes;
    logic [1:0]  qcount;
    logic [2:0]  kmode;
  } tok_cfg_t;

  typedef struct packed {
    logic [1:0] set_id;
    logic [7:0] text;
    logic       eos;
    logic       typed;
    out_item_t  exp_v;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // Configuration shadow, reset values
  logic [31:0] dl_bytes = 32'h20;
  logic [2:0]  dl_count = 3'd1;
  logic [15:0] qt_bytes = 16'h22;
  logic [1:0]  qt_count = 2'd1;
  logic [2:0]  keep_bits = 3'd0;

  // Token state
  bit tok_open, quote_on, esc_wait, kept_flag;

  out_item_t predicted_tokens[$];
  logic      use_typed = 1'b0;
  out_item_t typed_exp = '0;
  int        errors = 0;
  int        cycles = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b0;

  tok_cfg_t dir_sets [3] = '{
    '{32'h0000_0020, 3'd1, 16'h0022, 2'd1, 3'd0},
    '{32'hFF3B_2C00, 3'd4, 16'h5C27, 2'd2, 3'd4},
    '{32'hFF3B_2C00, 3'd4, 16'h5C27, 2'd2, 3'd1}
  };

  dir_row_t dir_rows [27] = '{
    '{2'd0, 8'h20, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},  // end outside a token
    '{2'd0, 8'h20, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},  // skipped delimiter
    '{2'd0, 8'h61, 1'b0, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0}},
    '{2'd0, 8'h22, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},  // open quote, dropped
    '{2'd0, 8'h20, 1'b0, 1'b1, '{8'h20, 1'b1, 1'b0, 1'b0}},  // delimiter inside quotes
    '{2'd0, 8'h22, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{2'd0, 8'h5C, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},  // escape, dropped
    '{2'd0, 8'h20, 1'b0, 1'b1, '{8'h20, 1'b1, 1'b0, 1'b0}},  // escaped delimiter
    '{2'd0, 8'h20, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},  // closing delimiter with end
    '{2'd0, 8'h22, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{2'd0, 8'h22, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{2'd0, 8'h20, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},  // empty token
    '{2'd0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{2'd0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},  // zero byte kept
    '{2'd0, 8'h22, 1'b0, 1'b0, '0},
    '{2'd0, 8'h78, 1'b1, 1'b0, '0},                          // end with quote open
    '{2'd0, 8'h5C, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},  // end with escape pending
    '{2'd0, 8'h5C, 1'b0, 1'b0, '0},
    '{2'd0, 8'h5C, 1'b0, 1'b0, '0},
    '{2'd0, 8'h62, 1'b1, 1'b0, '0},
    '{2'd1, 8'h27, 1'b0, 1'b0, '0},
    '{2'd1, 8'h5C, 1'b0, 1'b0, '0},                          // quote and backslash at once
    '{2'd1, 8'hFF, 1'b0, 1'b0, '0},
    '{2'd1, 8'h00, 1'b1, 1'b0, '0},
    '{2'd1, 8'h2C, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{2'd2, 8'h5C, 1'b0, 1'b0, '0},
    '{2'd2, 8'h71, 1'b1, 1'b0, '0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  quoted_field_tokenizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic bit slot_hit(logic [31:0] bytes_v, int unsigned cnt,
                                  int unsigned slots, logic [7:0] b);
    int unsigned n;
    n = (cnt < slots) ? cnt : slots;
    for (int unsigned i = 0; i < n; i++) begin
      if (bytes_v[8*i +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void drop_token_state();
    tok_open  = 1'b0;
    quote_on  = 1'b0;
    esc_wait  = 1'b0;
    kept_flag = 1'b0;
  endfunction

  function automatic out_item_t tokenize_byte(in_item_t it);
    out_item_t r;
    bit is_delim, quoting, keep, done, empty, esc;
    is_delim = slot_hit(dl_bytes, dl_count, DELIM_SLOTS, it.text_byte);
    quoting  = (qt_count != 0);
    keep  = 1'b0;
    done  = 1'b0;
    empty = 1'b0;
    if (!tok_open && is_delim) begin
      if (it.end_of_string) begin
        done  = 1'b1;
        empty = 1'b1;
      end
    end else if (tok_open && is_delim && !quote_on && !esc_wait) begin
      done  = 1'b1;
      empty = !kept_flag;
      drop_token_state();
    end else begin
      esc = esc_wait;
      if (!tok_open) begin
        tok_open  = 1'b1;
        quote_on  = 1'b0;
        esc       = 1'b0;
        kept_flag = 1'b0;
      end
      keep = 1'b1;
      if (quoting && !esc &&
          slot_hit({16'h0, qt_bytes}, qt_count, QUOTE_SLOTS, it.text_byte)) begin
        quote_on = !quote_on;
        if (!keep_bits[0]) keep = 1'b0;
      end
      if (quoting && !esc && it.text_byte == ESC_BYTE) begin
        esc_wait = 1'b1;
        if (!keep_bits[0] && !keep_bits[2]) keep = 1'b0;
      end else begin
        esc_wait = 1'b0;
      end
      if (keep) kept_flag = 1'b1;
      if (it.end_of_string) begin
        done  = 1'b1;
        empty = !kept_flag;
        drop_token_state();
      end
    end
    r.token_byte  = keep ? it.text_byte : 8'h00;
    r.byte_kept   = keep;
    r.token_done  = done;
    r.token_empty = done && empty;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] seen_v);
    if (seen_v !== want_v) begin
      $display("%0t: %s expected %h got %h", $time, name, want_v, seen_v);
      errors++;
    end
  endfunction

  // Score results first, then predict the transaction accepted at this edge
  always @(posedge clk) begin : score
    out_item_t seen, want;
    if (rst_n && out_valid && !out_stall) begin
      seen = out_data;
      if (predicted_tokens.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, seen);
        errors++;
      end else begin
        want = predicted_tokens.pop_front();
        check_field("token_byte", want.token_byte, seen.token_byte);
        check_field("byte_kept", 8'(want.byte_kept), 8'(seen.byte_kept));
        check_field("token_done", 8'(want.token_done), 8'(seen.token_done));
        check_field("token_empty", 8'(want.token_empty), 8'(seen.token_empty));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      want = tokenize_byte(in_data);
      predicted_tokens.push_back(use_typed ? typed_exp : want);
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= int'($urandom_range(0, 10));
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_byte(input in_item_t it, input bit typed, input out_item_t exp_v);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= it;
    use_typed <= typed;
    typed_exp <= exp_v;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender until every predicted token has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_tokens.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_setting(input tok_cfg_t s);
    cfg_reg_t    r;
    logic [31:0] v;
    for (int i = 0; i < REG_COUNT; i++) begin
      r = cfg_reg_t'(i);
      v = $urandom;
      case (r)
        REG_DELIM_BYTES: v = s.dbytes;
        REG_DELIM_COUNT: v[2:0] = s.dcount;
        REG_QUOTE_BYTES: v[15:0] = s.qbytes;
        REG_QUOTE_COUNT: v[1:0] = s.qcount;
        REG_KEEP_MODE:   v[2:0] = s.kmode;
        default: ;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= v;
      do @(posedge clk); while (!cfg_ready);
      case (r)
        REG_DELIM_BYTES: dl_bytes = v;
        REG_DELIM_COUNT: dl_count = v[2:0];
        REG_QUOTE_BYTES: qt_bytes = v[15:0];
        REG_QUOTE_COUNT: qt_count = v[1:0];
        REG_KEEP_MODE:   keep_bits = v[2:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic tok_cfg_t rand_setting();
    tok_cfg_t s;
    s.dbytes = $urandom;
    s.dcount = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    s.qbytes = 16'($urandom_range(0, 65535));
    s.qcount = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    s.kmode  = 3'($urandom_range(0, 7));
    return s;
  endfunction

  // Bias toward bytes that steer the token state
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 55) return dl_bytes[8*$urandom_range(0, 3) +: 8];
    if (r < 70) return qt_bytes[8*$urandom_range(0, 1) +: 8];
    if (r < 80) return ESC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stim
    in_item_t  it;
    tok_cfg_t  s;
    int        cur_set, len, n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;
    cur_set = 0;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].set_id != cur_set) begin
        wait_drained();
        load_setting(dir_sets[dir_rows[k].set_id]);
        cur_set = dir_rows[k].set_id;
      end
      it.text_byte     = dir_rows[k].text;
      it.end_of_string = dir_rows[k].eos;
      push_byte(it, dir_rows[k].typed, dir_rows[k].exp_v);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: s = dir_sets[0];
        1: s = '0;
        2: s = '{32'hFFFF_FFFF, 3'd7, 16'hFFFF, 2'd3, 3'd7};
        default: s = rand_setting();
      endcase
      load_setting(s);
      idle_on = (p != PHASES - 1) && (p % 3 != 2);
      n = 0;
      while (n < PHASE_ITEMS) begin
        len = ($urandom_range(0, 99) < 85) ? int'($urandom_range(1, 12)) : 0;
        if (len == 0) begin
          it.text_byte     = pick_byte();
          it.end_of_string = 1'($urandom_range(0, 1));
          push_byte(it, 1'b0, '0);
          n++;
          if (p == 4 && n == PHASE_ITEMS / 2) wait_drained();
        end else begin
          for (int j = 0; j < len; j++) begin
            it.text_byte     = pick_byte();
            it.end_of_string = (j == len - 1);
            push_byte(it, 1'b0, '0);
            n++;
            if (p == 4 && n == PHASE_ITEMS / 2) wait_drained();
          end
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/qft_pkg.sv
src/qft_front.sv
src/qft_queue.sv
src/qft_back.sv
src/quoted_field_tokenizer.sv
test/tb_top.sv
